/* design/dedup_lane_store_truncate_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dedup lane store
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DEDUP_LANE_STORE_TRUNCATE_TOP_ASSERT_SVH
`define DEDUP_LANE_STORE_TRUNCATE_TOP_ASSERT_SVH

// property holds on every active edge
`define DLST_ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("dlst: invariant violated");

// same-cycle implication
`define DLST_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dlst: implication violated");

// next-cycle implication
`define DLST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dlst: sequence violated");

`endif

/* design/dlst_pkg.sv */
// ----------------------------------------------------------------------------
// dlst_pkg
// Types, codes and widths shared by the dedup lane store modules.
// ----------------------------------------------------------------------------
package dlst_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TAG_W         = 32;
    localparam int OCC_W         = 5;
    localparam int CFG_W         = 5;
    localparam logic [CFG_W-1:0] CFG_LIMIT_RESET = 5'd16;

    typedef logic [OCC_W-1:0] t_occ;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef struct packed {
        t_status                  status;
        logic signed [TAG_W-1:0]  tag;
        t_occ                     occ;
        logic                     is_last;
    } t_result;

endpackage

/* design/dlst_ram.sv */
// ----------------------------------------------------------------------------
// dlst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dlst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/dlst_ctrl.sv */
// ----------------------------------------------------------------------------
// dlst_ctrl
// Sequencer for the tag store: circular-buffer addressing, RAM scan,
// insert commit, oldest-first removal emission and the result register.
// ----------------------------------------------------------------------------
`include "dedup_lane_store_truncate_top_assert.svh"

module dlst_ctrl #(
    parameter int DEPTH = dlst_pkg::DEPTH_DEFAULT,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_cmd,
    input  logic signed [dlst_pkg::TAG_W-1:0] i_tag,
    input  logic [CW-1:0]                   i_limit,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dlst_pkg::t_result               o_result,
    output logic                            o_ram_we,
    output logic [AW-1:0]                   o_ram_waddr,
    output logic [dlst_pkg::TAG_W-1:0]      o_ram_wdata,
    output logic [AW-1:0]                   o_ram_raddr,
    input  logic [dlst_pkg::TAG_W-1:0]      i_ram_rdata
);

    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_PHYS = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    t_state                          r_state;
    dlst_pkg::t_cmd                  r_cmd;
    logic signed [dlst_pkg::TAG_W-1:0] r_tag;
    logic [CW-1:0]                   r_count;
    logic [AW-1:0]                   r_head;
    logic [CW-1:0]                   r_idx;
    logic                            r_cmp_v;
    logic [AW-1:0]                   r_cmp_idx;
    logic [AW-1:0]                   r_pos;
    logic [AW-1:0]                   r_slot;
    logic                            r_out_valid;
    dlst_pkg::t_result               r_result;

    logic          can_load;
    logic          in_acc;
    logic          cmp_hit;
    logic          scan_end;
    logic [AW-1:0] head_m1;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] h, input logic [AW-1:0] i);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, i};
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    assign can_load   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && can_load;
    assign in_acc     = i_in_valid && o_in_ready;
    assign cmp_hit    = r_cmp_v && (i_ram_rdata == r_tag);
    assign scan_end   = !r_cmp_v && (r_idx == r_count);
    assign head_m1    = (r_head == '0) ? LAST_PHYS : r_head - 1'b1;

    assign o_ram_raddr = (r_state == S_SEARCH) ? f_phys(r_head, r_idx[AW-1:0])
                                               : f_phys(r_head, r_slot);
    assign o_ram_we    = (r_state == S_SEARCH) && scan_end && (r_cmd == dlst_pkg::CMD_INSERT);
    assign o_ram_waddr = head_m1;
    assign o_ram_wdata = r_tag;

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_head      <= '0;
            r_cmp_v     <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= dlst_pkg::t_cmd'(i_cmd);
                        r_tag   <= i_tag;
                        r_idx   <= '0;
                        r_cmp_v <= 1'b0;
                        unique case (dlst_pkg::t_cmd'(i_cmd))
                            dlst_pkg::CMD_INSERT: begin
                                if (r_count >= i_limit) begin
                                    r_out_valid <= 1'b1;
                                    r_result    <= '{dlst_pkg::ST_FULL, i_tag,
                                                     dlst_pkg::t_occ'(r_count), 1'b1};
                                end else begin
                                    r_state <= S_SEARCH;
                                end
                            end
                            dlst_pkg::CMD_REMOVE: begin
                                r_state <= S_SEARCH;
                            end
                            dlst_pkg::CMD_CLEAR: begin
                                r_count     <= '0;
                                r_out_valid <= 1'b1;
                                r_result    <= '{dlst_pkg::ST_CLEARED, i_tag, '0, 1'b1};
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (cmp_hit) begin
                        if (r_cmd == dlst_pkg::CMD_INSERT) begin
                            r_out_valid <= 1'b1;
                            r_result    <= '{dlst_pkg::ST_DUPLICATE, r_tag,
                                             dlst_pkg::t_occ'(r_count), 1'b1};
                            r_state     <= S_IDLE;
                        end else begin
                            r_pos   <= r_cmp_idx;
                            r_slot  <= AW'(r_count - 1'b1);
                            r_state <= S_EMIT_RD;
                        end
                        r_cmp_v <= 1'b0;
                    end else if (scan_end) begin
                        r_out_valid <= 1'b1;
                        if (r_cmd == dlst_pkg::CMD_INSERT) begin
                            r_head   <= head_m1;
                            r_count  <= r_count + 1'b1;
                            r_result <= '{dlst_pkg::ST_INSERTED, r_tag,
                                          dlst_pkg::t_occ'(r_count + 1'b1), 1'b1};
                        end else begin
                            r_result <= '{dlst_pkg::ST_NOT_FOUND, r_tag,
                                          dlst_pkg::t_occ'(r_count), 1'b1};
                        end
                        r_state <= S_IDLE;
                    end else if (r_idx < r_count) begin
                        r_cmp_v   <= 1'b1;
                        r_cmp_idx <= r_idx[AW-1:0];
                        r_idx     <= r_idx + 1'b1;
                    end else begin
                        r_cmp_v <= 1'b0;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_OUT;
                end
                S_EMIT_OUT: begin
                    if (can_load) begin
                        r_out_valid <= 1'b1;
                        r_result    <= '{dlst_pkg::ST_REMOVED, i_ram_rdata,
                                         dlst_pkg::t_occ'(r_slot), r_slot == r_pos};
                        if (r_slot == r_pos) begin
                            r_count <= CW'(r_pos);
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= r_slot - 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `DLST_ASSERT_IMPL(a_search_out_empty, i_clk, i_rst_n, r_state == S_SEARCH, !r_out_valid)
    `DLST_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `DLST_ASSERT_NEXT(a_emit_step, i_clk, i_rst_n,
        (r_state == S_EMIT_OUT) && can_load && (r_slot != r_pos),
        (r_state == S_EMIT_RD) && (r_slot == AW'($past(r_slot) - 1'b1)))

endmodule

/* design/dedup_lane_store_truncate_top.sv */
// ----------------------------------------------------------------------------
// dedup_lane_store_truncate_top
// Bounded, duplicate-free tag store, newest first, held in a block RAM.
// ----------------------------------------------------------------------------
// Commands arrive on the slave stream (tuser = command, tdata = tag). Tags live
// in a circular buffer in one RAM; an insert writes the slot just below the head.
// Full and clear answer in the cycle after the beat is taken. Insert and remove scan
// the RAM one entry per cycle from the newest, and the next beat is taken only
// once the result has loaded and the output can take a new result. A remove then
// emits one beat per departing entry, oldest first, each a RAM read then a result
// load, plus output stalls.
// The capacity register may be written only while the block is idle.

module dedup_lane_store_truncate_top #(
    parameter int DEPTH = dlst_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] tag_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] departed_tag, [36:32] occupancy, zero pad
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data      // [4:0] capacity_limit
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > dlst_pkg::CFG_W) ? CW : dlst_pkg::CFG_W;

    logic [dlst_pkg::CFG_W-1:0] r_cfg_limit;
    logic [LW-1:0]              cfg_ext;
    logic [LW-1:0]              lim_clamped;
    logic [CW-1:0]              limit;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [dlst_pkg::TAG_W-1:0]   ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [dlst_pkg::TAG_W-1:0]   ram_rdata;
    dlst_pkg::t_result            result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit <= dlst_pkg::CFG_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg_limit <= i_cfg_data;
        end
    end

    always_comb begin
        cfg_ext = LW'(r_cfg_limit);
        priority if (cfg_ext > LW'(DEPTH)) begin
            lim_clamped = LW'(DEPTH);
        end else if (cfg_ext == '0) begin
            lim_clamped = LW'(1);
        end else begin
            lim_clamped = cfg_ext;
        end
        limit = CW'(lim_clamped);
    end

    dlst_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_tag       (s_axis_tdata),
        .i_limit     (limit),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    dlst_ram #(
        .WIDTH (dlst_pkg::TAG_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tdata = {3'b000, result.occ, result.tag};
    assign m_axis_tuser = result.status;
    assign m_axis_tlast = result.is_last;

endmodule
